@@ rtl/bb_pkg.sv @@
// Shared types and constants for the 3x3 RGB box blur.
// No dependencies.
package bb_pkg;

    localparam int unsigned ChanW   = 16;
    localparam int unsigned PosW    = 10;
    localparam int unsigned CfgW    = 11;
    localparam int unsigned SumW    = 20;
    localparam int unsigned RecipW  = 25;
    localparam int unsigned RecipSh = 24;
    localparam int unsigned QDepth  = 4;
    localparam int unsigned QAw     = 2;

    typedef struct packed {
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] red;
    } t_pix;

    typedef struct packed {
        logic prev;
        logic cur;
        logic first;
        logic second;
    } t_axis;

    typedef struct packed {
        t_pix [8:0]      win;
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
        t_axis           rf;
        t_axis           cf;
    } t_job;

    typedef struct packed {
        logic [QAw:0] count;
        logic         empty;
    } t_qstat;

    function automatic logic [RecipW-1:0] recip(input logic [3:0] n);
        logic [RecipW-1:0] m;
        case (n)
            4'd2:    m = 25'd8388608;
            4'd3:    m = 25'd5592406;
            4'd4:    m = 25'd4194304;
            4'd6:    m = 25'd2796203;
            4'd9:    m = 25'd1864136;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/bb_if.sv @@
// Valid/ready channel interfaces for pixel input and blurred result output.
// Depends on bb_pkg.
interface bb_pix_if;
    import bb_pkg::*;
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bb_res_if;
    import bb_pkg::*;
    logic             valid;
    logic             ready;
    logic [PosW-1:0]  out_row;
    logic [PosW-1:0]  out_col;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             last_of_run;
    modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                    last_of_run, input ready);
    modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue,
                    last_of_run, output ready);
endinterface

@@ rtl/box_blur_3x3_rgb.sv @@
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb_pkg, bb_if, bb_front, bb_fifo, bb_back.
//
// Usage:
//   i_pix takes one raster-order pixel per transaction (valid/ready).
//   o_res gives blurred pixels with row, column and last_of_run, which marks
//   the final result caused by one input pixel. Inputs in row 0 and column 0
//   give no result (unless the image is one pixel wide or high); inputs in the
//   last row or column give two, and the last pixel of the image gives four.
//   i_cfg_we/i_cfg_data set the square image size (0 acts as 1, above MAX_DIM
//   acts as MAX_DIM) and restart at pixel (0,0); write only while idle.
// First result path: stage-1 register, job queue, back-end b0, b1, b2, output.
// Throughput: one input per cycle while each gives at most one result and the
//   receiver is ready; the back end issues one result per cycle, so last-row
//   pixels slow input. The 4-entry job queue parts input and output.
// Reset (synchronous, active low): image size 1, counters and window cleared,
//   queue and pipeline empty. Line store contents are not cleared.
// A stalled receiver holds the result register; the queue then fills and
//   i_pix.ready drops.
module box_blur_3x3_rgb
    import bb_pkg::*;
#(
    parameter int unsigned MAX_DIM = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CfgW-1:0] i_cfg_data,
    bb_pix_if.sink          i_pix,
    bb_res_if.source        o_res
);
    logic   w_push, w_pop;
    t_job   w_job, w_head;
    t_qstat w_qstat;

    bb_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    bb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    bb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );
endmodule

@@ rtl/bb_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/bb_front.sv @@
// Front end: raster counters, line store, 3x3 window and output classification.
// Depends on bb_pkg, bb_if, bb_ram.
module bb_front
    import bb_pkg::*;
#(
    parameter int unsigned MAX_DIM = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CfgW-1:0] i_cfg_data,
    bb_pix_if.sink          i_pix,
    input  t_qstat          i_qstat,
    output logic            o_push,
    output t_job            o_job
);
    localparam int unsigned CW = $clog2(MAX_DIM);
    localparam int unsigned EW = (CW + 1 > CfgW) ? CW + 1 : CfgW;

    logic [EW-1:0] r_dim;
    logic [CW-1:0] r_row, r_col;
    logic          r_s1_valid;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic [PosW-1:0] r_s1_row10, r_s1_col10;
    t_axis         r_s1_rf, r_s1_cf;
    t_pix [8:0]    r_win, n_win;
    logic [2*$bits(t_pix)-1:0] w_rd;
    logic [EW-1:0] w_last, w_cfg, w_row_e, w_col_e;
    logic          w_accept;
    t_axis         w_rf, w_cf;

    assign i_pix.ready = ({1'b0, i_qstat.count} + {{(QAw+1){1'b0}}, r_s1_valid})
                         < (QAw+2)'(QDepth);
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_last      = r_dim - EW'(1);
    assign w_row_e     = EW'(r_row);
    assign w_col_e     = EW'(r_col);
    assign w_cfg       = EW'(i_cfg_data);

    assign w_rf = '{prev: r_row != '0, cur: w_row_e == w_last,
                    first: r_row == '0, second: w_row_e == EW'(1)};
    assign w_cf = '{prev: r_col != '0, cur: w_col_e == w_last,
                    first: r_col == '0, second: w_col_e == EW'(1)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim      <= EW'(1);
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= w_accept;
            if (r_s1_valid) begin
                r_win <= n_win;
            end
            if (i_cfg_we) begin
                if (w_cfg == '0) begin
                    r_dim <= EW'(1);
                end else if (w_cfg > EW'(MAX_DIM)) begin
                    r_dim <= EW'(MAX_DIM);
                end else begin
                    r_dim <= w_cfg;
                end
                r_row <= '0;
                r_col <= '0;
            end else if (w_accept) begin
                if (w_col_e == w_last) begin
                    r_col <= '0;
                    r_row <= (w_row_e == w_last) ? '0 : r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix   <= '{blue: i_pix.in_blue, green: i_pix.in_green, red: i_pix.in_red};
            r_s1_col   <= r_col;
            r_s1_row10 <= PosW'(r_row);
            r_s1_col10 <= PosW'(r_col);
            r_s1_rf    <= w_rf;
            r_s1_cf    <= w_cf;
        end
    end

    bb_ram #(.WIDTH(2 * $bits(t_pix)), .DEPTH(MAX_DIM)) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({w_rd[$bits(t_pix)-1:0], r_s1_pix}),
        .i_raddr (r_col),
        .o_rdata (w_rd)
    );

    always_comb begin
        for (int wr = 0; wr < 3; wr++) begin
            n_win[wr*3]     = r_win[wr*3 + 1];
            n_win[wr*3 + 1] = r_win[wr*3 + 2];
        end
        n_win[2] = w_rd[2*$bits(t_pix)-1:$bits(t_pix)];
        n_win[5] = w_rd[$bits(t_pix)-1:0];
        n_win[8] = r_s1_pix;
    end

    assign o_push = r_s1_valid && (r_s1_rf.prev || r_s1_rf.cur) && (r_s1_cf.prev || r_s1_cf.cur);
    assign o_job  = '{win: n_win, row: r_s1_row10, col: r_s1_col10, rf: r_s1_rf, cf: r_s1_cf};
endmodule

@@ rtl/bb_fifo.sv @@
// Short job queue between the front end and the averaging back end.
// Depends on bb_pkg.
module bb_fifo
    import bb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_stat
);
    t_job           r_mem [QDepth];
    logic [QAw-1:0] r_wp, r_rp;
    logic [QAw:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAw'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAw'(1);
            end
            r_cnt <= r_cnt + (QAw+1)'(i_push) - (QAw+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head = r_mem[r_rp];
    assign o_stat = '{count: r_cnt, empty: r_cnt == '0};
endmodule

@@ rtl/bb_back.sv @@
// Back end: walks the outputs of each job, sums the clipped window, divides, registers.
// Depends on bb_pkg, bb_if.
module bb_back
    import bb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_qstat    i_qstat,
    output logic      o_pop,
    bb_res_if.source  o_res
);
    logic            r_i, r_j;
    logic            w_adv, w_li, w_lj, w_lastjob;
    logic [1:0]      w_orw, w_ocw;
    logic [3:0]      w_cnt;
    t_pix [8:0]      w_sel;

    logic            r_b0_v, r_b1_v, r_b2_v, r_out_valid;
    t_pix [8:0]      r_b0_pix;
    logic [3:0]      r_b0_cnt;
    logic [PosW-1:0] r_b0_row, r_b0_col, r_b1_row, r_b1_col, r_b2_row, r_b2_col;
    logic            r_b0_last, r_b1_last, r_b2_last;
    logic [SumW-1:0] r_b1_sr, r_b1_sg, r_b1_sb, n_sr, n_sg, n_sb;
    logic [RecipW-1:0] r_b1_m;
    logic [SumW+RecipW-1:0] r_b2_pr, r_b2_pg, r_b2_pb;
    logic [PosW-1:0] r_o_row, r_o_col;
    logic [ChanW-1:0] r_o_r, r_o_g, r_o_b;
    logic            r_o_last;

    assign w_adv     = !r_out_valid || o_res.ready;
    assign w_li      = !(i_head.rf.prev && i_head.rf.cur) || r_i;
    assign w_lj      = !(i_head.cf.prev && i_head.cf.cur) || r_j;
    assign w_lastjob = w_li && w_lj;
    assign o_pop     = w_adv && !i_qstat.empty && w_lastjob;
    assign w_orw     = (!r_i && i_head.rf.prev) ? 2'd1 : 2'd2;
    assign w_ocw     = (!r_j && i_head.cf.prev) ? 2'd1 : 2'd2;

    always_comb begin
        logic rok, cok;
        w_cnt = '0;
        for (int wr = 0; wr < 3; wr++) begin
            for (int wc = 0; wc < 3; wc++) begin
                rok = (2'(wr) >= w_orw - 2'd1) && (2'(wr) + 2'd1 >= w_orw)
                    && !(i_head.rf.first && wr < 2) && !(i_head.rf.second && wr < 1);
                cok = (2'(wc) >= w_ocw - 2'd1) && (2'(wc) + 2'd1 >= w_ocw)
                    && !(i_head.cf.first && wc < 2) && !(i_head.cf.second && wc < 1);
                w_sel[wr*3 + wc]  = (rok && cok) ? i_head.win[wr*3 + wc] : '0;
                w_cnt = w_cnt + 4'(rok && cok);
            end
        end
    end

    always_comb begin
        n_sr = '0;
        n_sg = '0;
        n_sb = '0;
        for (int k = 0; k < 9; k++) begin
            n_sr = n_sr + SumW'(r_b0_pix[k].red);
            n_sg = n_sg + SumW'(r_b0_pix[k].green);
            n_sb = n_sb + SumW'(r_b0_pix[k].blue);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= 1'b0;
            r_j         <= 1'b0;
            r_b0_v      <= 1'b0;
            r_b1_v      <= 1'b0;
            r_b2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b0_v      <= !i_qstat.empty;
            r_b1_v      <= r_b0_v;
            r_b2_v      <= r_b1_v;
            r_out_valid <= r_b2_v;
            if (!i_qstat.empty) begin
                if (w_lastjob) begin
                    r_i <= 1'b0;
                    r_j <= 1'b0;
                end else if (w_lj) begin
                    r_i <= 1'b1;
                    r_j <= 1'b0;
                end else begin
                    r_j <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b0_pix  <= w_sel;
            r_b0_cnt  <= w_cnt;
            r_b0_row  <= (w_orw == 2'd1) ? i_head.row - PosW'(1) : i_head.row;
            r_b0_col  <= (w_ocw == 2'd1) ? i_head.col - PosW'(1) : i_head.col;
            r_b0_last <= w_lastjob;
            r_b1_sr   <= n_sr;
            r_b1_sg   <= n_sg;
            r_b1_sb   <= n_sb;
            r_b1_m    <= recip(r_b0_cnt);
            r_b1_row  <= r_b0_row;
            r_b1_col  <= r_b0_col;
            r_b1_last <= r_b0_last;
            r_b2_pr   <= (SumW+RecipW)'(r_b1_sr) * (SumW+RecipW)'(r_b1_m);
            r_b2_pg   <= (SumW+RecipW)'(r_b1_sg) * (SumW+RecipW)'(r_b1_m);
            r_b2_pb   <= (SumW+RecipW)'(r_b1_sb) * (SumW+RecipW)'(r_b1_m);
            r_b2_row  <= r_b1_row;
            r_b2_col  <= r_b1_col;
            r_b2_last <= r_b1_last;
            r_o_r     <= r_b2_pr[RecipSh +: ChanW];
            r_o_g     <= r_b2_pg[RecipSh +: ChanW];
            r_o_b     <= r_b2_pb[RecipSh +: ChanW];
            r_o_row   <= r_b2_row;
            r_o_col   <= r_b2_col;
            r_o_last  <= r_b2_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_row     = r_o_row;
    assign o_res.out_col     = r_o_col;
    assign o_res.out_red     = r_o_r;
    assign o_res.out_green   = r_o_g;
    assign o_res.out_blue    = r_o_b;
    assign o_res.last_of_run = r_o_last;
endmodule

@@ rtl/bb_checker.sv @@
// Port-level checks for box_blur_3x3_rgb, attached by bind.
// Depends on bb_pkg.
module bb_checker
    import bb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             o_ready,
    input logic [PosW-1:0]  o_row,
    input logic [PosW-1:0]  o_col,
    input logic [ChanW-1:0] o_red,
    input logic             o_last
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_row) && $stable(o_col)
            && $stable(o_red) && $stable(o_last))
        else $error("stalled result changed");

    a_run_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready && !o_last |=> o_valid)
        else $error("gap inside a run of results");
endmodule

bind box_blur_3x3_rgb bb_checker u_bb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_res.valid),
    .o_ready (o_res.ready),
    .o_row   (o_res.out_row),
    .o_col   (o_res.out_col),
    .o_red   (o_res.out_red),
    .o_last  (o_res.last_of_run)
);
